@@ rtl/core/prb_pkg.sv @@
// Package of the packet reorder buffer: item structs, codes, FSM states.
// Used by every file of the block but prb_ram; depends on nothing.
`default_nettype none

package prb_pkg;

   localparam int PRB_DEPTH = 32;
   localparam int SEQ_W     = 32;
   localparam int HANDLE_W  = 16;
   localparam int HDR_W     = 32;
   localparam int SLOT_W    = HANDLE_W + HDR_W;
   localparam int MAXBUF_W  = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 32;

   localparam logic [SEQ_W-1:0]    INIT_SEQ_RESET = '0;
   localparam logic [MAXBUF_W-1:0] MAX_BUF_RESET  = 6'd32;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_GAP    = 1'b1;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_PACKET = 2'd1;
   localparam logic [1:0] KIND_GAP    = 2'd2;

   localparam logic [1:0] STAT_ACCEPTED  = 2'd0;
   localparam logic [1:0] STAT_DUPLICATE = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_BEYOND    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_SEQ = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BUF  = 1'd1;

   typedef struct packed {
      logic                command;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] packet_handle;
      logic [HDR_W-1:0]    header_word;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [1:0]          status;
      logic [SEQ_W-1:0]    out_seq;
      logic [HANDLE_W-1:0] out_handle;
      logic [HDR_W-1:0]    out_header;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic                wr_init;
      logic [SEQ_W-1:0]    init_value;
      logic [MAXBUF_W-1:0] max_buf;
   } cfg_type;

   typedef struct packed {
      logic    load;
      rsp_type data;
   } out_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_DRAIN,
      S_STATUS
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/packet_reorder_buffer_top.sv @@
// Top level of the packet reorder buffer: ports, control registers, result register.
// Depends on prb_pkg, prb_ctrl and prb_ram.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | req_data (prb_pkg::req_type)
//   rsp     | out       | rsp_valid/rsp_ready   | rsp_data (prb_pkg::rsp_type)
//   csr     | in        | csr_we                | csr_index, csr_wdata
//
// A command without drain passes the accept in S_IDLE and the window check in S_CHECK.
// A command that drains n slots gives one result per cycle while rsp_ready does not stall,
// bounded by the single read port of the slot RAM.
// Reset clears the slot marks and counters; RAM contents are kept.
// A stalled rsp_ready holds the sequencer; a new item is taken while a result waits.
`default_nettype none

module packet_reorder_buffer_top #(
   parameter int DEPTH = prb_pkg::PRB_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire prb_pkg::req_type                  req_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      prb_pkg::rsp_type                  rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [prb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [prb_pkg::CSR_W-1:0]         csr_wdata
);

   import prb_pkg::*;

   localparam int IW = $clog2(DEPTH);

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [MAXBUF_W-1:0] maxbuf_ff, maxbuf_in;

   cfg_type             cfg;
   out_type             out;
   logic                out_free;
   logic                ram_we, ram_re;
   logic [IW-1:0]       ram_waddr, ram_raddr;
   logic [SLOT_W-1:0]   ram_wdata, ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         maxbuf_ff    <= MAX_BUF_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         maxbuf_ff    <= maxbuf_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = out.load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = out.load ? out.data : rsp_data_ff;
      maxbuf_in    = (csr_we && csr_index == CSR_MAX_BUF) ?
                     csr_wdata[MAXBUF_W-1:0] : maxbuf_ff;
      cfg.wr_init    = csr_we && csr_index == CSR_INIT_SEQ;
      cfg.init_value = csr_wdata[SEQ_W-1:0];
      cfg.max_buf    = maxbuf_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   prb_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .out_free  (out_free),
      .out       (out),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   prb_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

@@ rtl/core/prb_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; holds the slot payloads of the reorder buffer.
`default_nettype none

module prb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/core/prb_ctrl.sv @@
// Sequencer of the reorder buffer: window check, slot marks, counters and drain.
// Depends on prb_pkg; drives the slot RAM and the result register in the top level.
`default_nettype none

module prb_ctrl #(
   parameter int DEPTH = prb_pkg::PRB_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire prb_pkg::req_type         req_data,
   input  wire prb_pkg::cfg_type         cfg,
   input  wire logic                     out_free,
   output      prb_pkg::out_type         out,
   output      logic                     ram_we,
   output      logic [$clog2(DEPTH)-1:0] ram_waddr,
   output      logic [prb_pkg::SLOT_W-1:0] ram_wdata,
   output      logic                     ram_re,
   output      logic [$clog2(DEPTH)-1:0] ram_raddr,
   input  wire logic [prb_pkg::SLOT_W-1:0] ram_rdata
);

   import prb_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type        state_ff, state_in;
   req_type          item_ff, item_in;
   logic [SEQ_W-1:0] d_ff, d_in;
   logic [SEQ_W-1:0] exp_ff, exp_in;
   logic [IW-1:0]    eidx_ff, eidx_in;
   logic [DEPTH-1:0] pkt_ff, pkt_in;
   logic [DEPTH-1:0] gap_ff, gap_in;
   logic [CW-1:0]    bufc_ff, bufc_in;
   logic [CW-1:0]    gapc_ff, gapc_in;
   logic [1:0]       status_ff, status_in;
   logic             pend_ff, pend_in;
   logic             pend_gap_ff, pend_gap_in;
   logic [SEQ_W-1:0] pend_seq_ff, pend_seq_in;

   logic          old, in_win, hp, hg, hit, issue_ok, drain_go;
   logic [IW:0]   sum;
   logic [IW-1:0] idx;
   logic [1:0]    st;
   rsp_type       status_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= INIT_SEQ_RESET;
         eidx_ff <= '0;
         pkt_ff  <= '0;
         gap_ff  <= '0;
         bufc_ff <= '0;
         gapc_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         exp_ff  <= exp_in;
         eidx_ff <= eidx_in;
         pkt_ff  <= pkt_in;
         gap_ff  <= gap_in;
         bufc_ff <= bufc_in;
         gapc_ff <= gapc_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      d_ff        <= d_in;
      status_ff   <= status_in;
      pend_gap_ff <= pend_gap_in;
      pend_seq_ff <= pend_seq_in;
   end

   always_comb begin
      old    = d_ff[SEQ_W-1];
      in_win = d_ff < SEQ_W'(DEPTH);
      sum    = {1'b0, eidx_ff} + {1'b0, d_ff[IW-1:0]};
      if (sum >= (IW+1)'(DEPTH)) begin
         sum = sum - (IW+1)'(DEPTH);
      end
      idx = in_win ? sum[IW-1:0] : '0;
      hp  = pkt_ff[idx];
      hg  = gap_ff[idx];
      hit = pkt_ff[eidx_ff] | gap_ff[eidx_ff];
      issue_ok = !pend_ff || out_free;
   end

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      d_in        = d_ff;
      exp_in      = exp_ff;
      eidx_in     = eidx_ff;
      pkt_in      = pkt_ff;
      gap_in      = gap_ff;
      bufc_in     = bufc_ff;
      gapc_in     = gapc_ff;
      status_in   = status_ff;
      pend_in     = pend_ff;
      pend_gap_in = pend_gap_ff;
      pend_seq_in = pend_seq_ff;
      req_ready   = 1'b0;
      out         = '0;
      ram_we      = 1'b0;
      ram_waddr   = idx;
      ram_wdata   = {item_ff.packet_handle, item_ff.header_word};
      ram_re      = 1'b0;
      ram_raddr   = eidx_ff;
      drain_go    = 1'b0;
      st          = STAT_ACCEPTED;

      status_rsp            = '0;
      status_rsp.kind       = KIND_STATUS;
      status_rsp.status     = status_ff;
      status_rsp.out_seq    = item_ff.seq;
      status_rsp.last       = 1'b1;

      if (cfg.wr_init && bufc_ff == '0 && gapc_ff == '0) begin
         exp_in = cfg.init_value;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               d_in     = req_data.seq - exp_ff;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            if (item_ff.command == CMD_GAP) begin
               if (old) begin
                  st = STAT_DUPLICATE;
               end else if (!in_win) begin
                  st = STAT_BEYOND;
               end else begin
                  if (hp) begin
                     pkt_in[idx] = 1'b0;
                     if (bufc_ff != '0) begin
                        bufc_in = bufc_ff - CW'(1);
                     end
                  end
                  if (!hg) begin
                     gapc_in = gapc_ff + CW'(1);
                  end
                  gap_in[idx] = 1'b1;
                  ram_we      = 1'b1;
                  ram_wdata   = {{HANDLE_W{1'b0}}, item_ff.header_word};
                  st          = STAT_ACCEPTED;
               end
            end else begin
               if (old || (in_win && hp)) begin
                  st = STAT_DUPLICATE;
               end else if (32'(bufc_ff) >= 32'(cfg.max_buf)) begin
                  st = STAT_FULL;
               end else if (!in_win) begin
                  st = STAT_BEYOND;
               end else begin
                  if (hg) begin
                     st = STAT_DUPLICATE;
                  end else begin
                     pkt_in[idx] = 1'b1;
                     bufc_in     = bufc_ff + CW'(1);
                     ram_we      = 1'b1;
                     st          = STAT_ACCEPTED;
                  end
                  drain_go = (d_ff == '0);
               end
            end
            status_in         = st;
            status_rsp.status = st;
            if (drain_go) begin
               pend_in  = 1'b0;
               state_in = S_DRAIN;
            end else if (out_free) begin
               out.load = 1'b1;
               out.data = status_rsp;
               state_in = S_IDLE;
            end else begin
               state_in = S_STATUS;
            end
         end

         S_DRAIN: begin
            if (pend_ff && out_free) begin
               out.load            = 1'b1;
               out.data.kind       = pend_gap_ff ? KIND_GAP : KIND_PACKET;
               out.data.status     = STAT_ACCEPTED;
               out.data.out_seq    = pend_seq_ff;
               out.data.out_handle = pend_gap_ff ? '0 : ram_rdata[SLOT_W-1:HDR_W];
               out.data.out_header = ram_rdata[HDR_W-1:0];
               out.data.last       = 1'b0;
            end
            if (issue_ok) begin
               if (hit) begin
                  ram_re      = 1'b1;
                  pend_in     = 1'b1;
                  pend_gap_in = gap_ff[eidx_ff];
                  pend_seq_in = exp_ff;
                  if (gap_ff[eidx_ff]) begin
                     gap_in[eidx_ff] = 1'b0;
                     gapc_in         = gapc_ff - CW'(1);
                  end else begin
                     pkt_in[eidx_ff] = 1'b0;
                     if (bufc_ff != '0) begin
                        bufc_in = bufc_ff - CW'(1);
                     end
                  end
                  exp_in  = exp_ff + SEQ_W'(1);
                  eidx_in = (eidx_ff == IW'(DEPTH - 1)) ? '0 : eidx_ff + IW'(1);
               end else begin
                  pend_in  = 1'b0;
                  state_in = S_STATUS;
               end
            end
         end

         S_STATUS: begin
            if (out_free) begin
               out.load = 1'b1;
               out.data = status_rsp;
               state_in = S_IDLE;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/prb_checker.sv @@
// Port-level checks of the packet reorder buffer and their bind to the top level.
// Depends on prb_pkg and packet_reorder_buffer_top.
`default_nettype none

module prb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire prb_pkg::req_type              req_data,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire prb_pkg::rsp_type              rsp_data,
   input wire logic                          csr_we,
   input wire logic [prb_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [prb_pkg::CSR_W-1:0]     csr_wdata
);

   import prb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is still being worked on");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.kind == KIND_STATUS)))
      else $error("last flag does not match a status item");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_STATUS |->
         rsp_data.out_handle == '0 && rsp_data.out_header == '0)
      else $error("status item carries packet data");

   a_drain_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_STATUS |->
         rsp_data.status == STAT_ACCEPTED &&
         (rsp_data.kind == KIND_PACKET || rsp_data.kind == KIND_GAP))
      else $error("delivery item with bad kind or status");

endmodule

bind packet_reorder_buffer_top prb_checker u_prb_checker (.*);

`default_nettype wire

@@ tb/prb_result_check.sv @@
`timescale 1ns / 100ps
// Result check for the packet reorder buffer: follows the req, rsp and csr ports,
// keeps its own copy of the reorder window and compares every rsp item in order.
// Depends on prb_pkg only.
module prb_result_check (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire prb_pkg::req_type              req_data,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire prb_pkg::rsp_type              rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [prb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [prb_pkg::CSR_W-1:0]     csr_wdata,
   output int                                 fail_count,
   output int                                 pending,
   output logic [prb_pkg::SEQ_W-1:0]          next_seq
);

   import prb_pkg::*;

   logic [SEQ_W-1:0]    init_seq_reg;
   logic [MAXBUF_W-1:0] max_held;
   logic [SEQ_W-1:0]    want_seq;
   bit                  has_pkt [PRB_DEPTH];
   bit                  has_gap [PRB_DEPTH];
   logic [HANDLE_W-1:0] slot_hnd [PRB_DEPTH];
   logic [HDR_W-1:0]    slot_phdr [PRB_DEPTH];
   logic [HDR_W-1:0]    slot_ghdr [PRB_DEPTH];
   int unsigned         held;
   rsp_type             due_results [$];
   int                  errors = 0;

   function automatic rsp_type make_rsp(input logic [1:0] kind, input logic [1:0] status,
                                        input logic [SEQ_W-1:0] sq,
                                        input logic [HANDLE_W-1:0] hnd,
                                        input logic [HDR_W-1:0] hdr, input logic last);
      rsp_type r;
      r.kind       = kind;
      r.status     = status;
      r.out_seq    = sq;
      r.out_handle = hnd;
      r.out_header = hdr;
      r.last       = last;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ERROR %s", $realtime, what);
      errors++;
   endtask

   task automatic clear_window_model();
      init_seq_reg = INIT_SEQ_RESET;
      max_held     = MAX_BUF_RESET;
      want_seq     = INIT_SEQ_RESET;
      held         = 0;
      for (int i = 0; i < PRB_DEPTH; i++) begin
         has_pkt[i]   = 1'b0;
         has_gap[i]   = 1'b0;
         slot_hnd[i]  = '0;
         slot_phdr[i] = '0;
         slot_ghdr[i] = '0;
      end
      due_results.delete();
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      bit empty;
      empty = 1'b1;
      if (idx == CSR_INIT_SEQ) begin
         init_seq_reg = data;
         for (int i = 0; i < PRB_DEPTH; i++) begin
            if (has_pkt[i] || has_gap[i]) begin
               empty = 1'b0;
            end
         end
         if (empty) begin
            want_seq = init_seq_reg;
         end
      end else if (idx == CSR_MAX_BUF) begin
         max_held = data[MAXBUF_W-1:0];
      end
   endtask

   task automatic predict_results(input req_type r);
      logic [SEQ_W-1:0] delta;
      bit               old;
      bit               in_win;
      int               idx;
      int               slot;
      logic [1:0]       st;
      delta  = r.seq - want_seq;
      old    = delta[SEQ_W-1];
      in_win = delta < PRB_DEPTH;
      idx    = int'(r.seq % PRB_DEPTH);
      if (r.command == CMD_GAP) begin
         if (old) begin
            st = STAT_DUPLICATE;
         end else if (!in_win) begin
            st = STAT_BEYOND;
         end else begin
            if (has_pkt[idx]) begin
               has_pkt[idx] = 1'b0;
               if (held > 0) held--;
            end
            has_gap[idx]   = 1'b1;
            slot_ghdr[idx] = r.header_word;
            st             = STAT_ACCEPTED;
         end
      end else begin
         if (old || (in_win && has_pkt[idx])) begin
            st = STAT_DUPLICATE;
         end else if (held >= max_held) begin
            st = STAT_FULL;
         end else if (!in_win) begin
            st = STAT_BEYOND;
         end else begin
            if (has_gap[idx]) begin
               st = STAT_DUPLICATE;
            end else begin
               has_pkt[idx]   = 1'b1;
               slot_hnd[idx]  = r.packet_handle;
               slot_phdr[idx] = r.header_word;
               held++;
               st = STAT_ACCEPTED;
            end
            if (delta == 0) begin
               for (int steps = 0; steps < PRB_DEPTH; steps++) begin
                  slot = int'(want_seq % PRB_DEPTH);
                  if (has_gap[slot]) begin
                     due_results.push_back(make_rsp(KIND_GAP, STAT_ACCEPTED, want_seq, '0,
                                                    slot_ghdr[slot], 1'b0));
                     has_gap[slot] = 1'b0;
                  end else if (has_pkt[slot]) begin
                     due_results.push_back(make_rsp(KIND_PACKET, STAT_ACCEPTED, want_seq,
                                                    slot_hnd[slot], slot_phdr[slot], 1'b0));
                     has_pkt[slot] = 1'b0;
                     if (held > 0) held--;
                  end else begin
                     break;
                  end
                  want_seq++;
               end
            end
         end
      end
      due_results.push_back(make_rsp(KIND_STATUS, st, r.seq, '0, '0, 1'b1));
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("result item with nothing due: kind %0d seq %h",
                                   got.kind, got.out_seq));
      end else begin
         want = due_results.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("kind got %0d expected %0d at seq %h",
                                      got.kind, want.kind, want.out_seq));
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d at seq %h",
                                      got.status, want.status, want.out_seq));
         if (got.out_seq !== want.out_seq)
            report_mismatch($sformatf("out_seq got %h expected %h",
                                      got.out_seq, want.out_seq));
         if (got.out_handle !== want.out_handle)
            report_mismatch($sformatf("out_handle got %h expected %h at seq %h",
                                      got.out_handle, want.out_handle, want.out_seq));
         if (got.out_header !== want.out_header)
            report_mismatch($sformatf("out_header got %h expected %h at seq %h",
                                      got.out_header, want.out_header, want.out_seq));
         if (got.last !== want.last)
            report_mismatch($sformatf("last got %b expected %b at seq %h",
                                      got.last, want.last, want.out_seq));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_window_model();
      end else begin
         if (csr_we) write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) predict_results(req_data);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
      fail_count <= errors;
      pending    <= due_results.size();
      next_seq   <= want_seq;
   end

endmodule

@@ tb/tb_packet_reorder_buffer_top.sv @@
`timescale 1ns / 100ps
// Testbench top of the packet reorder buffer: clock, reset, command stimulus,
// register writes and the verdict. Depends on prb_pkg, prb_result_check and the block.
module tb_packet_reorder_buffer_top;
   import prb_pkg::*;

   localparam logic [SEQ_W-1:0] PHASE_INIT [5] = '{32'hFFFF_FFF0, 32'h7FFF_FFF8, 32'h0000_0000,
                                                   32'h0000_0000, 32'hFFFF_FFFF};
   localparam int PHASE_MAX   [5] = '{32, 4, 0, 17, 32};
   localparam int PHASE_ITEMS [5] = '{35, 35, 10, 35, 35};
   localparam int SEND_IDLE   [5] = '{0, 78, 0, 18, 0};
   localparam int RECV_STALL  [5] = '{0, 0, 78, 18, 78};

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   int                   fail_count;
   int                   pending;
   logic [SEQ_W-1:0]     next_seq;
   int                   send_idle_pct = 0;
   int                   stall_pct     = 0;
   int                   items_sent    = 0;

   packet_reorder_buffer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   prb_result_check u_result_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .next_seq   (next_seq)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic req_type make_req(input logic cmd, input logic [SEQ_W-1:0] seq);
      req_type item;
      item.command       = cmd;
      item.seq           = seq;
      item.packet_handle = HANDLE_W'($urandom);
      item.header_word   = $urandom;
      return item;
   endfunction

   function automatic req_type make_noise(input logic [SEQ_W-1:0] base, input int span);
      req_type item;
      item = make_req(1'($urandom_range(1)), base);
      case ($urandom_range(4))
         0: item.seq = base - $urandom_range(32'h8000_0000, 1);
         1: item.seq = base + $urandom_range(32'h7FFF_FFFF, PRB_DEPTH);
         2: item.seq = $urandom;
         3: begin
            case ($urandom_range(3))
               0:       item.seq = base + PRB_DEPTH;
               1:       item.seq = base - 1;
               2:       item.seq = base + 32'h8000_0000;
               default: item.seq = base + 32'h7FFF_FFFF;
            endcase
         end
         default: item.seq = base + $urandom_range(span - 1);
      endcase
      return item;
   endfunction

   task automatic send_req(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic quiesce();
      wait_results();
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Gap marks over the whole window, then an insert at the expected sequence,
   // which skips every gap and leaves the window empty.
   task automatic clear_window();
      logic [SEQ_W-1:0] base;
      wait_results();
      base = next_seq;
      for (int j = 0; j < PRB_DEPTH; j++) begin
         send_req(make_req(CMD_GAP, base + j));
      end
      send_req(make_req(CMD_INSERT, base));
   endtask

   // Fills the slots after the expected sequence in random order, then inserts
   // the expected packet last so that the whole run drains at once, unless that insert is refused as full.
   task automatic run_burst();
      req_type          plan [$];
      req_type          tmp;
      logic [SEQ_W-1:0] base;
      logic [SEQ_W-1:0] s;
      int               span;
      int               pick;
      wait_results();
      base = next_seq;
      span = ($urandom_range(9) == 0) ? $urandom_range(PRB_DEPTH, 16) : $urandom_range(6, 1);
      for (int j = 1; j < span; j++) begin
         s = base + j;
         case ($urandom_range(4))
            0: plan.push_back(make_req(CMD_INSERT, s));
            1: plan.push_back(make_req(CMD_GAP, s));
            2: begin
               plan.push_back(make_req(CMD_INSERT, s));
               plan.push_back(make_req(CMD_GAP, s));
            end
            3: begin
               plan.push_back(make_req(CMD_GAP, s));
               plan.push_back(make_req(CMD_GAP, s));
            end
            default: begin
               plan.push_back(make_req(CMD_INSERT, s));
               plan.push_back(make_req(CMD_INSERT, s));
            end
         endcase
      end
      if ($urandom_range(2) == 0) plan.push_back(make_req(CMD_GAP, base));
      for (int j = plan.size() - 1; j > 0; j--) begin
         pick       = $urandom_range(j);
         tmp        = plan[j];
         plan[j]    = plan[pick];
         plan[pick] = tmp;
      end
      plan.push_back(make_req(CMD_INSERT, base));
      foreach (plan[j]) begin
         if ($urandom_range(99) < 15) send_req(make_noise(base, span));
         send_req(plan[j]);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_req(req_type'{CMD_INSERT, 32'd1, 16'h0000, 32'h0000_0000});
      send_req(req_type'{CMD_GAP, 32'd2, 16'h0000, 32'hFFFF_FFFF});
      send_req(req_type'{CMD_INSERT, 32'd2, 16'hFFFF, 32'hFFFF_FFFF});
      send_req(req_type'{CMD_INSERT, 32'd1, 16'h1234, 32'h5555_AAAA});
      send_req(req_type'{CMD_GAP, 32'd3, 16'h0000, 32'hAAAA_5555});
      send_req(req_type'{CMD_GAP, 32'd3, 16'hFFFF, 32'h0F0F_F0F0});
      send_req(req_type'{CMD_INSERT, 32'd4, 16'hA5A5, 32'h1357_9BDF});
      send_req(req_type'{CMD_GAP, 32'd4, 16'h0000, 32'h2468_ACE0});
      send_req(req_type'{CMD_GAP, 32'd0, 16'h0000, 32'hDEAD_0000});
      send_req(req_type'{CMD_INSERT, 32'd0, 16'h5A5A, 32'h0000_BEEF});
      send_req(req_type'{CMD_INSERT, 32'd3, 16'h0001, 32'h0000_0001});
      send_req(req_type'{CMD_GAP, 32'd0, 16'h0000, 32'h0000_0002});
      send_req(req_type'{CMD_INSERT, 32'd37, 16'h0002, 32'h0000_0003});
      send_req(req_type'{CMD_GAP, 32'd37, 16'h0000, 32'h0000_0004});
      send_req(req_type'{CMD_INSERT, 32'd36, 16'hFFFF, 32'hFFFF_FFFF});
      send_req(req_type'{CMD_INSERT, 32'd5, 16'h0000, 32'h0000_0000});
      send_req(req_type'{CMD_INSERT, 32'h8000_0005, 16'h0003, 32'h0000_0005});
      send_req(req_type'{CMD_INSERT, 32'h8000_0006, 16'h0004, 32'h0000_0006});
      send_req(req_type'{CMD_GAP, 32'h8000_0006, 16'h0000, 32'h0000_0007});
      send_req(req_type'{CMD_GAP, 32'h8000_0005, 16'h0000, 32'h0000_0008});
      quiesce();
      csr_write(CSR_MAX_BUF, CSR_W'(1));
      csr_we <= 1'b0;
      send_req(req_type'{CMD_INSERT, 32'd7, 16'h0005, 32'h0000_0009});
      send_req(req_type'{CMD_INSERT, 32'd6, 16'h0006, 32'h0000_000A});
      send_req(req_type'{CMD_INSERT, 32'd36, 16'h0007, 32'h0000_000B});

      for (int p = 0; p < 5; p++) begin
         quiesce();
         send_idle_pct = SEND_IDLE[p];
         stall_pct     = RECV_STALL[p];
         csr_write(CSR_MAX_BUF, CSR_W'(MAX_BUF_RESET));
         csr_we <= 1'b0;
         clear_window();
         quiesce();
         csr_write(CSR_INIT_SEQ, (p == 3) ? CSR_W'($urandom) : PHASE_INIT[p]);
         csr_write(CSR_MAX_BUF, CSR_W'(PHASE_MAX[p]));
         csr_we <= 1'b0;
         items_sent = 0;
         while (items_sent < PHASE_ITEMS[p]) run_burst();
      end

      quiesce();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS packet_reorder_buffer_top");
      end else begin
         $display("FAIL packet_reorder_buffer_top");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL packet_reorder_buffer_top");
      $finish;
   end

endmodule
